// File: rtl/mfld_pkg.sv
// ----------------------------------------------------------------------------
// mfld_pkg
// Types and fixed constants of the monochrome frame store line drawer.
// ----------------------------------------------------------------------------
package mfld_pkg;

  // Operation codes of an input item.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Largest coordinates that the endpoint fields can carry.
  localparam int CoordXMax = 127;
  localparam int CoordYMax = 63;

  // Register address bit that selects a register (one register, word aligned).
  localparam logic REG_DRAW_COLOR = 1'b0;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SETUP  = 6'b000100,
    ST_DRAW   = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

endpackage

// File: rtl/mono_framebuffer_line_drawer.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer
// One-bit-per-pixel frame store with a Bresenham line rasterizer and a byte
// read port.
// ----------------------------------------------------------------------------
// After reset the block zeroes the frame store, one byte a cycle, all
// (DISPLAY_WIDTH*DISPLAY_HEIGHT+7)/8 bytes (1024 by default), and takes no
// item meanwhile. It then handles one item at a time. A line item walks
// max(|dx|,|dy|) + 1 pixels, one pixel a cycle, reading the store byte and
// writing it back in the cycle after, with the last write forwarded when
// neighboring pixels share a byte. Each item gives one result; a result that
// is stalled waits in the output register and the block holds in its final
// state until the register frees.
module mono_framebuffer_line_drawer
  import mfld_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [6:0]  start_x_i,
  input  logic [5:0]  start_y_i,
  input  logic [6:0]  end_x_i,
  input  logic [5:0]  end_y_i,
  input  logic [9:0]  byte_address_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        was_read_o,
  output logic [7:0]  read_data_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STORE_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PIX_MAX     = CoordYMax * DISPLAY_WIDTH + CoordXMax;
  localparam int PIX_W       = $clog2(PIX_MAX + 1);

  // Configuration.
  logic color_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_DRAW_COLOR) ? {31'b0, color_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == REG_DRAW_COLOR) begin
      color_q <= pwdata[0];
    end
  end

  // Control and walk registers.
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [6:0]        sx_q, ex_q;
  logic [5:0]        sy_q, ey_q;
  logic [6:0]        dl_q, dl_d, ds_q, ds_d, n_q, n_d;
  logic [7:0]        err_q, err_d;
  logic [PIX_W-1:0]  pix_q, pix_d, step_long_q, step_long_d, step_diag_q, step_diag_d;
  logic              rd_ok_q, rd_ok_d;

  // Store access pipeline.
  logic [7:0]        mem [STORE_BYTES];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rdata_q;
  logic              b_valid_q, b_valid_d;
  logic [ADDR_W-1:0] b_addr_q;
  logic [2:0]        b_bit_q;
  logic              w_valid_q;
  logic [ADDR_W-1:0] w_addr_q;
  logic [7:0]        w_data_q;
  logic [7:0]        merged, mask, new_byte;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic       out_was_read_q;
  logic [7:0] out_data_q;
  logic       out_free, out_load, out_load_read;

  logic        in_acc;
  logic [31:0] in_byte_wide, pix_byte_wide;
  logic        in_addr_ok, pix_ok;

  // Setup arithmetic.
  logic signed [7:0] dx, dy;
  logic [6:0]        adx, ady;
  logic [PIX_W-1:0]  st_x, st_y, pw;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i & ~in_stall_o;
  assign in_byte_wide = 32'(byte_address_i);
  assign in_addr_ok   = in_byte_wide < 32'(STORE_BYTES);
  assign pix_byte_wide = 32'(pix_q[PIX_W-1:3]);
  assign pix_ok        = pix_byte_wide < 32'(STORE_BYTES);

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign was_read_o  = out_was_read_q;
  assign read_data_o = out_data_q;

  always_comb begin
    dx  = $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
    dy  = $signed({2'b0, ey_q}) - $signed({2'b0, sy_q});
    adx = dx[7] ? 7'(-dx) : dx[6:0];
    ady = dy[7] ? 7'(-dy) : dy[6:0];
    pw  = PIX_W'(DISPLAY_WIDTH);
    st_x = dx > 0 ? PIX_W'(1) : PIX_W'(0) - PIX_W'(1);
    st_y = dy > 0 ? pw : PIX_W'(0) - pw;
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    dl_d          = dl_q;
    ds_d          = ds_q;
    n_d           = n_q;
    err_d         = err_q;
    pix_d         = pix_q;
    step_long_d   = step_long_q;
    step_diag_d   = step_diag_q;
    rd_ok_d       = rd_ok_q;
    rd_en         = 1'b0;
    rd_addr       = pix_byte_wide[ADDR_W-1:0];
    b_valid_d     = 1'b0;
    out_load      = 1'b0;
    out_load_read = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_READ) begin
            rd_en   = in_addr_ok;
            rd_addr = in_byte_wide[ADDR_W-1:0];
            rd_ok_d = in_addr_ok;
            state_d = ST_RDWAIT;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // On a tie the x axis is the major one.
        if (adx >= ady) begin
          dl_d        = adx;
          ds_d        = ady;
          step_long_d = st_x;
          step_diag_d = st_x + st_y;
        end else begin
          dl_d        = ady;
          ds_d        = adx;
          step_long_d = st_y;
          step_diag_d = st_x + st_y;
        end
        err_d   = {1'b0, dl_d} >> 1;
        pix_d   = PIX_W'(sy_q) * pw + PIX_W'(sx_q);
        n_d     = 7'd0;
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        // Pixels whose byte lies past the end of the store are skipped.
        rd_en     = pix_ok;
        b_valid_d = pix_ok;
        if (err_q >= {1'b0, dl_q}) begin
          pix_d = pix_q + step_diag_q;
          err_d = 8'(9'(err_q) + 9'(ds_q) - 9'(dl_q));
        end else begin
          pix_d = pix_q + step_long_q;
          err_d = 8'(9'(err_q) + 9'(ds_q));
        end
        n_d = n_q + 7'd1;
        if (n_q == dl_q) begin
          state_d = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_read = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The read issued at the edge of the previous write sees the old byte, so
  // that write is forwarded when it hits the same byte.
  always_comb begin
    merged   = (w_valid_q && w_addr_q == b_addr_q) ? w_data_q : rdata_q;
    mask     = 8'(1) << b_bit_q;
    new_byte = color_q ? (merged | mask) : (merged & ~mask);
    we       = (state_q == ST_CLEAR) | b_valid_q;
    wr_addr  = (state_q == ST_CLEAR) ? clr_q : b_addr_q;
    wr_data  = (state_q == ST_CLEAR) ? 8'd0 : new_byte;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      n_q         <= 7'd0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      b_valid_q   <= b_valid_d;
      w_valid_q   <= b_valid_q;
      out_valid_q <= out_valid_d;
      rd_ok_q     <= rd_ok_d;
      n_q         <= n_d;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
    dl_q        <= dl_d;
    ds_q        <= ds_d;
    err_q       <= err_d;
    pix_q       <= pix_d;
    step_long_q <= step_long_d;
    step_diag_q <= step_diag_d;
    b_addr_q    <= pix_byte_wide[ADDR_W-1:0];
    b_bit_q     <= pix_q[2:0];
    if (b_valid_q) begin
      w_addr_q <= b_addr_q;
      w_data_q <= new_byte;
    end
    if (out_load) begin
      out_was_read_q <= out_load_read;
      out_data_q     <= (out_load_read && rd_ok_q) ? rdata_q : 8'd0;
    end
  end

endmodule
